FILE: rtl/mdrf_pkg.sv
// Package: widths, codes, CSR indices and types for the mesh dedup relay filter.
package mdrf_pkg;
   localparam int unsigned CacheEntriesDefault = 16;
   localparam int unsigned CsrIdxWidth = 3;

   localparam logic [1:0] MODE_RECV   = 2'd0;
   localparam logic [1:0] MODE_SEND   = 2'd1;
   localparam logic [1:0] MODE_PURGE  = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   localparam logic [2:0] VERDICT_OK      = 3'd0;
   localparam logic [2:0] VERDICT_SELF    = 3'd1;
   localparam logic [2:0] VERDICT_BAD     = 3'd2;
   localparam logic [2:0] VERDICT_DUP     = 3'd3;
   localparam logic [2:0] VERDICT_TTL     = 3'd4;

   localparam logic [CsrIdxWidth-1:0] CSR_OWN_ID    = 3'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_BCAST_ID  = 3'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_WINDOW    = 3'd2;
   localparam logic [CsrIdxWidth-1:0] CSR_MAX_HOPS  = 3'd3;
   localparam logic [CsrIdxWidth-1:0] CSR_START_HOPS = 3'd4;
   localparam logic [CsrIdxWidth-1:0] CSR_RELAY_MASK = 3'd5;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] now_ms;
      logic        decode_ok;
      logic [31:0] src_node;
      logic [31:0] dest_id;
      logic [31:0] msg_id;
      logic [7:0]  hops_left;
      logic [7:0]  pkt_flags;
   } req_type;

   typedef struct packed {
      logic [2:0]  verdict;
      logic        deliver;
      logic        relay;
      logic [7:0]  out_hops;
      logic [7:0]  out_flags;
      logic [31:0] out_sender;
      logic [31:0] relayed_total;
      logic [31:0] dropped_total;
   } rsp_type;

   // one cache line: sender, message, stamp
   typedef struct packed {
      logic [31:0] sender;
      logic [31:0] msg;
      logic [31:0] stamp;
   } line_type;
endpackage

FILE: rtl/mdrf_if.sv
// Interfaces: request and response channels.
interface mdrf_req_if import mdrf_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mdrf_rsp_if import mdrf_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/mesh_dedup_relay_filter_top.sv
// Top level: duplicate-suppression cache and relay decision for mesh packets.
//
// Requests arrive on req (valid/ready). Each carries a mode: received packet,
// own send, or purge tick. One response per request leaves on rsp.
// The cache lives in one RAM (sender, message, stamp per line) with a
// valid bit per line in flip-flops. A purge tick, or a received packet that decoded
// and is not from own_id, scans the cache one line per cycle through the RAM read
// port before its response is built in the done state; an own send, an unused mode
// or any other received packet goes straight from idle to the done state.
// One request is worked at a time; req_ready is high only in the idle state
// while the response register is free or being taken.
// The response stays in an output register until rsp_ready; a stalled
// receiver holds the block after the current request.
// Reset (synchronous, active high) clears the valid bits, the head
// pointer, the counters and restores register defaults; RAM contents are
// left as they are and are ignored until written.
// csr_we writes register csr_index with csr_wdata at once; the user must
// write only while the block is idle; the block itself does not enforce it.
module mesh_dedup_relay_filter_top import mdrf_pkg::*; #(
   parameter int unsigned CACHE_ENTRIES = CacheEntriesDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   mdrf_req_if.sink               req,
   mdrf_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [31:0]            csr_wdata
);
   localparam int unsigned AW = $clog2(CACHE_ENTRIES);
   localparam logic [AW-1:0] LastIdx = AW'(CACHE_ENTRIES - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   // configuration registers
   logic [31:0] own_id_ff, bcast_id_ff, window_ff;
   logic [7:0]  max_hops_ff, start_hops_ff, relay_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff     <= '0;
         bcast_id_ff   <= '1;
         window_ff     <= 32'd30000;
         max_hops_ff   <= 8'd7;
         start_hops_ff <= 8'd3;
         relay_mask_ff <= 8'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:     own_id_ff     <= csr_wdata;
            CSR_BCAST_ID:   bcast_id_ff   <= csr_wdata;
            CSR_WINDOW:     window_ff     <= csr_wdata;
            CSR_MAX_HOPS:   max_hops_ff   <= csr_wdata[7:0];
            CSR_START_HOPS: start_hops_ff <= csr_wdata[7:0];
            CSR_RELAY_MASK: relay_mask_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // control state
   logic [1:0]   state_ff, state_in;
   req_type      cur_ff, cur_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;   // address being read
   logic [AW-1:0] cmp_idx_ff, cmp_idx_in; // line whose data is on rd_data
   logic         cmp_vld_ff, cmp_vld_in;
   logic         hit_ff, hit_in;
   logic [CACHE_ENTRIES-1:0] valid_ff, valid_in;
   logic [AW-1:0] head_ff, head_in;
   logic [31:0]  relayed_ff, relayed_in, dropped_ff, dropped_in;
   logic         rsp_vld_ff, rsp_vld_in;
   rsp_type      rsp_ff, rsp_in;

   // RAM port signals
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   line_type      wr_data, rd_data;

   mdrf_ram #(.Width($bits(line_type)), .Depth(CACHE_ENTRIES)) u_cache (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   logic        out_free;
   logic [31:0] age;
   logic        line_vld;
   assign out_free  = !rsp_vld_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;
   assign rsp.valid = rsp_vld_ff;
   assign rsp.data  = rsp_ff;
   assign age       = cur_ff.now_ms - rd_data.stamp;
   assign line_vld  = valid_ff[cmp_idx_ff];

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      hit_in     = hit_ff;
      valid_in   = valid_ff;
      head_in    = head_ff;
      relayed_in = relayed_ff;
      dropped_in = dropped_ff;
      rsp_vld_in = rsp_vld_ff && !rsp.ready;
      rsp_in     = rsp_ff;
      wr_en      = 1'b0;
      wr_addr    = head_ff;
      wr_data    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               cur_in    = req.data;
               rd_idx_in = '0;
               hit_in    = 1'b0;
               if (req.data.mode == MODE_PURGE ||
                   (req.data.mode == MODE_RECV && req.data.decode_ok &&
                    req.data.src_node != own_id_ff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            // issue reads, then compare each line in the cycle after its read
            if (rd_idx_ff != LastIdx || !cmp_vld_ff || cmp_idx_ff != LastIdx) begin
               if (!(cmp_vld_ff && cmp_idx_ff == LastIdx)) begin
                  cmp_idx_in = rd_idx_ff;
                  cmp_vld_in = 1'b1;
                  if (rd_idx_ff != LastIdx) rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
            if (cmp_vld_ff && line_vld) begin
               if (cur_ff.mode == MODE_PURGE) begin
                  if (age > window_ff) valid_in[cmp_idx_ff] = 1'b0;
               end else if (rd_data.sender == cur_ff.src_node &&
                            rd_data.msg == cur_ff.msg_id && age < window_ff) begin
                  hit_in = 1'b1;
               end
            end
            if (cmp_vld_ff && cmp_idx_ff == LastIdx) begin
               cmp_vld_in = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in = 1'b1;
               rsp_in     = '0;
               state_in   = ST_IDLE;
               case (cur_ff.mode)
                  MODE_RECV: begin
                     if (!cur_ff.decode_ok) begin
                        rsp_in.verdict = VERDICT_BAD;
                        dropped_in     = dropped_ff + 32'd1;
                     end else if (cur_ff.src_node == own_id_ff) begin
                        rsp_in.verdict = VERDICT_SELF;
                     end else if (hit_ff) begin
                        rsp_in.verdict = VERDICT_DUP;
                        dropped_in     = dropped_ff + 32'd1;
                     end else begin
                        wr_en   = 1'b1;
                        wr_data = '{cur_ff.src_node, cur_ff.msg_id, cur_ff.now_ms};
                        valid_in[head_ff] = 1'b1;
                        head_in = (head_ff == LastIdx) ? '0 : head_ff + AW'(1);
                        if (cur_ff.hops_left > max_hops_ff) begin
                           rsp_in.verdict = VERDICT_TTL;
                           dropped_in     = dropped_ff + 32'd1;
                        end else begin
                           rsp_in.verdict    = VERDICT_OK;
                           rsp_in.deliver    = (cur_ff.dest_id == own_id_ff) ||
                                               (cur_ff.dest_id == bcast_id_ff);
                           rsp_in.out_hops   = cur_ff.hops_left;
                           rsp_in.out_flags  = cur_ff.pkt_flags;
                           rsp_in.out_sender = cur_ff.src_node;
                           if (cur_ff.hops_left != 8'd0 && cur_ff.dest_id != own_id_ff) begin
                              rsp_in.relay     = 1'b1;
                              rsp_in.out_hops  = cur_ff.hops_left - 8'd1;
                              rsp_in.out_flags = cur_ff.pkt_flags | relay_mask_ff;
                              relayed_in       = relayed_ff + 32'd1;
                           end
                        end
                     end
                  end
                  MODE_SEND: begin
                     wr_en   = 1'b1;
                     wr_data = '{own_id_ff, cur_ff.msg_id, cur_ff.now_ms};
                     valid_in[head_ff] = 1'b1;
                     head_in = (head_ff == LastIdx) ? '0 : head_ff + AW'(1);
                     rsp_in.out_hops   = start_hops_ff;
                     rsp_in.out_flags  = cur_ff.pkt_flags;
                     rsp_in.out_sender = own_id_ff;
                  end
                  default: ;
               endcase
               rsp_in.relayed_total = relayed_in;
               rsp_in.dropped_total = dropped_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         head_ff    <= '0;
         relayed_ff <= '0;
         dropped_ff <= '0;
         rsp_vld_ff <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         head_ff    <= head_in;
         relayed_ff <= relayed_in;
         dropped_ff <= dropped_in;
         rsp_vld_ff <= rsp_vld_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      rsp_ff     <= rsp_in;
   end
endmodule

FILE: rtl/mdrf_ram.sv
// Generic single-port-write, single-read RAM with registered read.
module mdrf_ram #(
   parameter int unsigned Width = 8,
   parameter int unsigned Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: rtl/mdrf_checker.sv
// Checker on the top-level ports, with its bind.
module mdrf_checker import mdrf_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // no new request right after one is accepted
   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // rejected packets carry no relay and no delivery
   a_no_relay_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.verdict != VERDICT_OK |-> !rsp_data.relay && !rsp_data.deliver)
      else $error("relay on rejected packet");

   // relay implies decremented hops never wraps to all ones from zero
   a_relay_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.relay |-> rsp_data.out_hops != 8'hFF)
      else $error("relay with bad hops");
endmodule

bind mesh_dedup_relay_filter_top mdrf_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

FILE: tb/mesh_dedup_relay_filter_top_test.sv
// Testbench: random and directed requests against a behavioral dedup cache predictor.
module mesh_dedup_relay_filter_top_test;
   import mdrf_pkg::*;

   localparam int Entries = CacheEntriesDefault;
   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   mdrf_req_if req_ch ();
   mdrf_rsp_if rsp_ch ();

   mesh_dedup_relay_filter_top #(.CACHE_ENTRIES(Entries)) dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] own_id, bcast_id, window;
   logic [7:0]  max_hops, start_hops, relay_mask;
   logic [31:0] c_snd [Entries];
   logic [31:0] c_msg [Entries];
   logic [31:0] c_stamp [Entries];
   logic        c_valid [Entries];
   int          head;
   logic [31:0] relayed_cnt, dropped_cnt;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int  fail_count = 0;
   bit  hold_armed = 0;
   bit  hold_taken = 0;
   int  hold_left = 0;
   int  idle_cycles = 0;

   task automatic predictor_reset();
      own_id = 0; bcast_id = 32'hFFFF_FFFF; window = 30000;
      max_hops = 7; start_hops = 3; relay_mask = 1;
      for (int i = 0; i < Entries; i++) begin
         c_snd[i] = 0; c_msg[i] = 0; c_stamp[i] = 0; c_valid[i] = 0;
      end
      head = 0; relayed_cnt = 0; dropped_cnt = 0;
   endtask

   function automatic bit recently_seen(logic [31:0] s, logic [31:0] m, logic [31:0] now);
      logic [31:0] age;
      for (int i = 0; i < Entries; i++) begin
         age = now - c_stamp[i];
         if (c_valid[i] && c_snd[i] == s && c_msg[i] == m && age < window) return 1;
      end
      return 0;
   endfunction

   task automatic cache_insert(logic [31:0] s, logic [31:0] m, logic [31:0] now);
      c_snd[head] = s; c_msg[head] = m; c_stamp[head] = now; c_valid[head] = 1;
      head = (head + 1) % Entries;
   endtask

   // compute the response for one accepted request
   task automatic predict_filter(req_type r);
      rsp_type o;
      logic [31:0] age;
      o = '0;
      if (r.mode == MODE_RECV) begin
         if (!r.decode_ok) begin
            o.verdict = VERDICT_BAD; dropped_cnt++;
         end else if (r.src_node == own_id) begin
            o.verdict = VERDICT_SELF;
         end else if (recently_seen(r.src_node, r.msg_id, r.now_ms)) begin
            o.verdict = VERDICT_DUP; dropped_cnt++;
         end else begin
            cache_insert(r.src_node, r.msg_id, r.now_ms);
            if (r.hops_left > max_hops) begin
               o.verdict = VERDICT_TTL; dropped_cnt++;
            end else begin
               o.verdict = VERDICT_OK;
               o.deliver = (r.dest_id == own_id) || (r.dest_id == bcast_id);
               o.out_hops = r.hops_left;
               o.out_flags = r.pkt_flags;
               o.out_sender = r.src_node;
               if (r.hops_left != 0 && r.dest_id != own_id) begin
                  o.relay = 1;
                  o.out_hops = r.hops_left - 8'd1;
                  o.out_flags = r.pkt_flags | relay_mask;
                  relayed_cnt++;
               end
            end
         end
      end else if (r.mode == MODE_SEND) begin
         cache_insert(own_id, r.msg_id, r.now_ms);
         o.out_hops = start_hops; o.out_flags = r.pkt_flags; o.out_sender = own_id;
      end else if (r.mode == MODE_PURGE) begin
         for (int i = 0; i < Entries; i++) begin
            age = r.now_ms - c_stamp[i];
            if (c_valid[i] && age > window) begin
               c_valid[i] = 0; c_snd[i] = 0; c_msg[i] = 0; c_stamp[i] = 0;
            end
         end
      end
      o.relayed_total = relayed_cnt;
      o.dropped_total = dropped_cnt;
      expected_rsps.push_back(o);
   endtask

   // driver: bursts and gaps
   int burst_left = 0, gap_left = 0;
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
   end
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_filter(req_ch.data);
            void'(pending_reqs.pop_front());
            if (burst_left > 0) burst_left--;
            else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_reqs[0];
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern and monitor
   int stall_mode = 0;
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsps.size() == 0) begin
               $error("response with none expected");
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (e.verdict !== rsp_ch.data.verdict) begin
                  $error("verdict exp %0d got %0d", e.verdict, rsp_ch.data.verdict);
                  fail_count++;
               end
               if (e.deliver !== rsp_ch.data.deliver) begin
                  $error("deliver exp %0d got %0d", e.deliver, rsp_ch.data.deliver);
                  fail_count++;
               end
               if (e.relay !== rsp_ch.data.relay) begin
                  $error("relay exp %0d got %0d", e.relay, rsp_ch.data.relay);
                  fail_count++;
               end
               if (e.out_hops !== rsp_ch.data.out_hops) begin
                  $error("out_hops exp %0d got %0d", e.out_hops, rsp_ch.data.out_hops);
                  fail_count++;
               end
               if (e.out_flags !== rsp_ch.data.out_flags) begin
                  $error("out_flags exp %0h got %0h", e.out_flags, rsp_ch.data.out_flags);
                  fail_count++;
               end
               if (e.out_sender !== rsp_ch.data.out_sender) begin
                  $error("out_sender exp %0h got %0h", e.out_sender,
                         rsp_ch.data.out_sender);
                  fail_count++;
               end
               if (e.relayed_total !== rsp_ch.data.relayed_total) begin
                  $error("relayed_total exp %0d got %0d", e.relayed_total,
                         rsp_ch.data.relayed_total);
                  fail_count++;
               end
               if (e.dropped_total !== rsp_ch.data.dropped_total) begin
                  $error("dropped_total exp %0d got %0d", e.dropped_total,
                         rsp_ch.data.dropped_total);
                  fail_count++;
               end
            end
         end
         // long hold, counted here once armed
         if (hold_armed && !hold_taken) begin
            hold_taken = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (hold_left > 0) || reset)
         idle_cycles <= 0;
      else if (expected_rsps.size() > 0 || pending_reqs.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("mesh_dedup_relay_filter_top_test: FAIL");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [CsrIdxWidth-1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_OWN_ID:     own_id = val;
         CSR_BCAST_ID:   bcast_id = val;
         CSR_WINDOW:     window = val;
         CSR_MAX_HOPS:   max_hops = val[7:0];
         CSR_START_HOPS: start_hops = val[7:0];
         CSR_RELAY_MASK: relay_mask = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (Entries + 10) @(posedge clock);
   endtask

   function automatic req_type mk(logic [1:0] m, logic [31:0] now, bit ok,
                                  logic [31:0] s, logic [31:0] d, logic [31:0] msg,
                                  logic [7:0] h, logic [7:0] f);
      req_type r;
      r.mode = m; r.now_ms = now; r.decode_ok = ok; r.src_node = s;
      r.dest_id = d; r.msg_id = msg; r.hops_left = h; r.pkt_flags = f;
      return r;
   endfunction

   // random request from small id pools so duplicates occur
   function automatic req_type rand_req(ref logic [31:0] clk_ms);
      req_type r;
      int p;
      p = $urandom_range(0, 99);
      clk_ms += ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3000);
      r.now_ms = clk_ms;
      r.mode = (p < 70) ? MODE_RECV : (p < 82) ? MODE_SEND : (p < 95) ? MODE_PURGE
               : MODE_UNUSED;
      r.decode_ok = ($urandom_range(0, 9) != 0);
      r.src_node = ($urandom_range(0, 5) == 0) ? own_id
                   : ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4);
      r.dest_id = ($urandom_range(0, 3) == 0) ? own_id
                  : ($urandom_range(0, 2) == 0) ? bcast_id : $urandom;
      r.msg_id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6);
      r.hops_left = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 9);
      r.pkt_flags = $urandom;
      if ($urandom_range(0, 9) == 0) r.msg_id = 0;
      return r;
   endfunction

   initial begin
      logic [31:0] clk_ms;
      predictor_reset();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part with default settings but own id 0x10
      csr_write(CSR_OWN_ID, 32'h0000_0010);
      pending_reqs.push_back(mk(MODE_RECV, 0, 0, 5, 16, 1, 0, 0));
      pending_reqs.push_back(mk(MODE_RECV, 0, 1, 32'h10, 16, 1, 0, 0));
      pending_reqs.push_back(mk(MODE_RECV, 0, 1, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(MODE_RECV, 100, 1, 5, 32'hFFFF_FFFF, 1, 7, 8'hF0));
      pending_reqs.push_back(mk(MODE_RECV, 200, 1, 5, 32'hFFFF_FFFF, 1, 7, 8'hF0));
      pending_reqs.push_back(mk(MODE_RECV, 300, 1, 6, 16, 2, 3, 8'hFF));
      pending_reqs.push_back(mk(MODE_RECV, 300, 1, 7, 9, 3, 8, 0));
      pending_reqs.push_back(mk(MODE_RECV, 400, 1, 7, 9, 3, 2, 0));
      pending_reqs.push_back(mk(MODE_RECV, 400, 1, 32'hFFFF_FFFF, 9, 32'hFFFF_FFFF,
                                8'hFF, 8'hFF));
      pending_reqs.push_back(mk(MODE_SEND, 500, 1, 0, 0, 9, 0, 8'hAA));
      pending_reqs.push_back(mk(MODE_RECV, 600, 1, 32'h11, 0, 9, 0, 0));
      pending_reqs.push_back(mk(MODE_RECV, 30600, 1, 8, 3, 4, 1, 0));
      pending_reqs.push_back(mk(MODE_RECV, 30700, 1, 5, 3, 1, 1, 0));
      pending_reqs.push_back(mk(MODE_PURGE, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
      pending_reqs.push_back(mk(MODE_RECV, 32'h8000_0001, 1, 6, 16, 2, 1, 0));
      pending_reqs.push_back(mk(MODE_UNUSED, 32'hFFFF_FFFF, 1, 1, 1, 1, 1, 1));
      pending_reqs.push_back(mk(MODE_RECV, 32'hFFFF_FFFF, 1, 9, 9, 9, 1, 0));
      pending_reqs.push_back(mk(MODE_RECV, 32'h0000_0005, 1, 9, 9, 9, 1, 0));
      drain();

      // random phases across settings, extremes included
      clk_ms = 0;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               csr_write(CSR_OWN_ID, 0); csr_write(CSR_BCAST_ID, 0);
               csr_write(CSR_WINDOW, 1); csr_write(CSR_MAX_HOPS, 0);
               csr_write(CSR_START_HOPS, 0); csr_write(CSR_RELAY_MASK, 0);
            end
            1: begin
               csr_write(CSR_OWN_ID, 32'hFFFF_FFFF); csr_write(CSR_BCAST_ID, 32'h3);
               csr_write(CSR_WINDOW, 32'hFFFF_FFFF); csr_write(CSR_MAX_HOPS, 8'hFF);
               csr_write(CSR_START_HOPS, 8'hFF); csr_write(CSR_RELAY_MASK, 8'hFF);
            end
            default: begin
               csr_write(CSR_OWN_ID, $urandom_range(1, 4));
               csr_write(CSR_BCAST_ID, ($urandom_range(0, 1)) ? 32'hFFFF_FFFF : $urandom);
               csr_write(CSR_WINDOW, $urandom_range(1, 20000));
               csr_write(CSR_MAX_HOPS, $urandom_range(0, 10));
               csr_write(CSR_START_HOPS, $urandom);
               csr_write(CSR_RELAY_MASK, $urandom);
            end
         endcase
         for (int k = 0; k < 300; k++) pending_reqs.push_back(rand_req(clk_ms));
         if (ph == 2) begin
            // long receiver hold while the sender keeps offering
            hold_armed = 1;
            while (!hold_taken || hold_left > 0) @(posedge clock);
         end
         if (ph == 3) begin
            // sender pauses until everything is back
            while (pending_reqs.size() > 150) @(posedge clock);
            begin
               req_type hold_q [$];
               hold_q = pending_reqs[1:$];
               pending_reqs = pending_reqs[0:0];
               while (pending_reqs.size() > 0 || expected_rsps.size() > 0)
                  @(posedge clock);
               pending_reqs = hold_q;
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("mesh_dedup_relay_filter_top_test: PASS");
      end else begin
         $display("mesh_dedup_relay_filter_top_test: FAIL");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/mdrf_pkg.sv
rtl/mdrf_if.sv
rtl/mdrf_ram.sv
rtl/mesh_dedup_relay_filter_top.sv
rtl/mdrf_checker.sv
tb/mesh_dedup_relay_filter_top_test.sv
